/* hdl/job_sequencing_slot_fill_assert.svh */
// Assertion macros shared by the job sequencing RTL.
`ifndef JOB_SEQUENCING_SLOT_FILL_ASSERT_SVH
`define JOB_SEQUENCING_SLOT_FILL_ASSERT_SVH

// Same-cycle implication, checked on the rising clock edge, off during reset.
`define JSF_ASSERT_IMP(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("jsf assertion failed");

// Next-cycle implication, checked on the rising clock edge, off during reset.
`define JSF_ASSERT_NXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("jsf assertion failed");

`endif

/* hdl/jsf_pkg.sv */
// ---------------------------------------------------------------------------
// jsf_pkg: shared types and constants
// Sizes, payload structs and control types of the job sequencing block.
// ---------------------------------------------------------------------------
`default_nettype none

package jsf_pkg;

  localparam int MAX_JOBS = 256;
  localparam int IDX_W    = $clog2(MAX_JOBS);
  localparam int CNT_W    = $clog2(MAX_JOBS + 1);
  localparam int RUN_W    = $clog2(2 * MAX_JOBS);
  localparam int RUN_LAST = 2 * MAX_JOBS - 1;
  localparam int FLD_W    = 16;
  localparam int JCNT_W   = 9;
  localparam int TOT_W    = 24;

  typedef struct packed {
    logic [FLD_W-1:0] deadline;
    logic [FLD_W-1:0] profit;
    logic             last_job;
  } jsf_in_t;

  typedef struct packed {
    logic [JCNT_W-1:0] job_count;
    logic [TOT_W-1:0]  total_profit;
  } jsf_out_t;

  // One job as it moves through the sort chain and the slot chain.
  typedef struct packed {
    logic             valid;
    logic             placed;
    logic [FLD_W-1:0] deadline;
    logic [FLD_W-1:0] profit;
  } jsf_tok_t;

  typedef struct packed {
    logic load;
    logic shift;
  } jsf_sort_ctrl_t;

  typedef enum logic {
    ST_LOAD,
    ST_RUN
  } jsf_state_e;

endpackage

`default_nettype wire

/* hdl/jsf_sort_cell.sv */
// ---------------------------------------------------------------------------
// jsf_sort_cell: one cell of the profit sort chain
// Holds one job; on load it keeps the chain sorted by falling profit, on
// shift it takes its right neighbor so the head drains one job a cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module jsf_sort_cell import jsf_pkg::*; (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire jsf_sort_ctrl_t ctrl_i,
  input  wire jsf_tok_t       new_i,
  input  wire jsf_tok_t       left_i,
  input  wire logic           left_ins_i,
  input  wire jsf_tok_t       right_i,
  output jsf_tok_t            ent_o,
  output logic                ins_o
);

  jsf_tok_t ent_q, ent_d;

  // insertion point: empty or strictly lower profit, so ties keep load order
  assign ins_o = !ent_q.valid || (new_i.profit > ent_q.profit);

  always_comb begin
    ent_d = ent_q;
    if (ctrl_i.shift) begin
      ent_d = right_i;
    end else if (ctrl_i.load) begin
      if (left_ins_i) begin
        ent_d = left_i;
      end else if (ins_o) begin
        ent_d = new_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_q <= '0;
    end else begin
      ent_q <= ent_d;
    end
  end

  assign ent_o = ent_q;

endmodule

`default_nettype wire

/* hdl/jsf_slot_cell.sv */
// ---------------------------------------------------------------------------
// jsf_slot_cell: one time slot of the slot chain
// Jobs pass downward one cell a cycle; the first free slot below the
// deadline that a job meets takes it, which is the latest free slot.
// ---------------------------------------------------------------------------
`default_nettype none

module jsf_slot_cell import jsf_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire jsf_tok_t         tok_i,
  input  wire logic [IDX_W-1:0] idx_i,
  input  wire logic [CNT_W-1:0] n_i,
  input  wire logic             clear_i,
  output jsf_tok_t              tok_o
);

  jsf_tok_t tok_q, tok_d;
  logic     taken_q, taken_d;
  logic     hit;

  // take the job when open, in range of the set and before its deadline
  assign hit = tok_i.valid && !tok_i.placed && !taken_q
            && ({1'b0, idx_i} < n_i) && (FLD_W'(idx_i) < tok_i.deadline);

  always_comb begin
    tok_d        = tok_i;
    tok_d.placed = tok_i.placed | hit;
    taken_d      = clear_i ? 1'b0 : (taken_q | hit);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q   <= '0;
      taken_q <= 1'b0;
    end else begin
      tok_q   <= tok_d;
      taken_q <= taken_d;
    end
  end

  assign tok_o = tok_q;

endmodule

`default_nettype wire

/* hdl/job_sequencing_slot_fill.sv */
// ---------------------------------------------------------------------------
// job_sequencing_slot_fill: greedy job sequencing with deadlines
// Loads (deadline, profit) jobs, schedules them by falling profit into the
// latest free slot, and reports the job count and total profit.
// ---------------------------------------------------------------------------
// Usage: drive job_i and raise start_i; a job transfers at each edge with
// start_i high and busy_o low. Jobs load at one per cycle into a sorted
// chain of MAX_JOBS cells. The job with last_job set ends the set; jobs
// beyond MAX_JOBS are ignored, but the last flag still ends the set.
// After the last job, busy_o stays high while cnt_q counts up to RUN_LAST:
// the sort chain drains one job a cycle into a chain of MAX_JOBS slot
// cells, which each job walks from the top slot down, one cell a cycle.
// res_valid_o then pulses for one cycle with res_o; the next set can
// start in that same cycle. Non-final jobs produce no result.
// The receiver cannot stall: res_valid_o is high for a single cycle.
// Reset (rst_ni low) empties both chains, frees all slots and clears the
// job counter; no clearing pass is needed afterwards.
// ---------------------------------------------------------------------------
`default_nettype none
`include "job_sequencing_slot_fill_assert.svh"

module job_sequencing_slot_fill import jsf_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    start_i,
  input  wire jsf_in_t job_i,
  output logic         busy_o,
  output logic         res_valid_o,
  output jsf_out_t     res_o
);

  jsf_state_e        state_q, state_d;
  logic [CNT_W-1:0]  loaded_q, loaded_d;
  logic [RUN_W-1:0]  cnt_q, cnt_d;
  logic [JCNT_W-1:0] acc_cnt_q, acc_cnt_d;
  logic [TOT_W-1:0]  acc_tot_q, acc_tot_d;
  logic              res_valid_q, res_valid_d;
  jsf_out_t          res_q, res_d;

  logic              accept;
  logic              finish;
  logic              gain;
  jsf_sort_ctrl_t    sort_ctrl;
  jsf_tok_t          new_tok;
  jsf_tok_t          inject;
  jsf_tok_t          sort_ent [MAX_JOBS];
  logic              sort_ins [MAX_JOBS];
  jsf_tok_t          slot_tok [MAX_JOBS];
  logic [JCNT_W-1:0] cnt_sum;
  logic [TOT_W-1:0]  tot_sum;

  assign busy_o = (state_q == ST_RUN);
  assign accept = start_i && !busy_o;
  assign finish = (state_q == ST_RUN) && (cnt_q == RUN_W'(RUN_LAST));

  always_comb begin
    new_tok          = '0;
    new_tok.valid    = 1'b1;
    new_tok.deadline = job_i.deadline;
    new_tok.profit   = job_i.profit;
    sort_ctrl.load   = accept && (loaded_q < CNT_W'(MAX_JOBS));
    sort_ctrl.shift  = (state_q == ST_RUN);
    inject           = (state_q == ST_RUN) ? sort_ent[0] : '0;
  end

  // sort chain: cell 0 is the head with the highest profit
  for (genvar g = 0; g < MAX_JOBS; g++) begin : g_sort
    jsf_tok_t left_tok, right_tok;
    logic     left_ins;
    if (g == 0) begin : g_first
      assign left_tok = '0;
      assign left_ins = 1'b0;
    end else begin : g_mid
      assign left_tok = sort_ent[g-1];
      assign left_ins = sort_ins[g-1];
    end
    if (g == MAX_JOBS - 1) begin : g_last
      assign right_tok = '0;
    end else begin : g_inner
      assign right_tok = sort_ent[g+1];
    end
    jsf_sort_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (sort_ctrl),
      .new_i      (new_tok),
      .left_i     (left_tok),
      .left_ins_i (left_ins),
      .right_i    (right_tok),
      .ent_o      (sort_ent[g]),
      .ins_o      (sort_ins[g])
    );
  end

  // slot chain: jobs enter at the top slot and walk down to slot 0
  for (genvar g = 0; g < MAX_JOBS; g++) begin : g_slot
    jsf_tok_t tok_in;
    if (g == MAX_JOBS - 1) begin : g_top
      assign tok_in = inject;
    end else begin : g_below
      assign tok_in = slot_tok[g+1];
    end
    jsf_slot_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .tok_i   (tok_in),
      .idx_i   (IDX_W'(g)),
      .n_i     (loaded_q),
      .clear_i (finish),
      .tok_o   (slot_tok[g])
    );
  end

  // add up the placed jobs leaving the bottom slot
  assign gain    = slot_tok[0].valid && slot_tok[0].placed;
  assign cnt_sum = acc_cnt_q + JCNT_W'(gain);
  assign tot_sum = acc_tot_q + (gain ? TOT_W'(slot_tok[0].profit) : '0);

  always_comb begin
    state_d     = state_q;
    loaded_d    = loaded_q;
    cnt_d       = cnt_q;
    acc_cnt_d   = acc_cnt_q;
    acc_tot_d   = acc_tot_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    case (state_q)
      ST_LOAD: begin
        if (sort_ctrl.load) begin
          loaded_d = loaded_q + CNT_W'(1);
        end
        if (accept && job_i.last_job) begin
          state_d = ST_RUN;
          cnt_d   = '0;
        end
      end
      ST_RUN: begin
        cnt_d     = cnt_q + RUN_W'(1);
        acc_cnt_d = cnt_sum;
        acc_tot_d = tot_sum;
        if (finish) begin
          state_d            = ST_LOAD;
          loaded_d           = '0;
          acc_cnt_d          = '0;
          acc_tot_d          = '0;
          res_valid_d        = 1'b1;
          res_d.job_count    = cnt_sum;
          res_d.total_profit = tot_sum;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      loaded_q    <= '0;
      cnt_q       <= '0;
      acc_cnt_q   <= '0;
      acc_tot_q   <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      loaded_q    <= loaded_d;
      cnt_q       <= cnt_d;
      acc_cnt_q   <= acc_cnt_d;
      acc_tot_q   <= acc_tot_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  `JSF_ASSERT_IMP(a_res_after_run, clk_i, rst_ni, res_valid_o, $past(state_q == ST_RUN))
  `JSF_ASSERT_IMP(a_res_idle, clk_i, rst_ni, res_valid_o, !busy_o && loaded_q == '0)
  `JSF_ASSERT_IMP(a_load_bound, clk_i, rst_ni, 1'b1, loaded_q <= CNT_W'(MAX_JOBS))
  `JSF_ASSERT_NXT(a_finish_frees, clk_i, rst_ni, finish, !busy_o && acc_cnt_q == '0)

endmodule

`default_nettype wire
